>>> sv/mer_pkg.sv
// Shared constants for the midpoint ellipse rasterizer.
// Widths, phase codes and stream packing; no dependencies.
`timescale 1ns / 1ps
package mer_pkg;

	localparam int COORD_BITS = 12;

	localparam int CoordW = COORD_BITS;
	localparam int AxisW  = COORD_BITS - 1;
	localparam int OffW   = COORD_BITS;
	localparam int SqW    = 2 * AxisW;
	localparam int ProdW  = SqW + OffW;
	localparam int PixW   = COORD_BITS + 2;
	localparam int QuadW  = 2;
	localparam int DecW   = 48;

	localparam int SFieldW = 2 * CoordW + 2 * AxisW;
	localparam int SDataW  = ((SFieldW + 7) / 8) * 8;
	localparam int MFieldW = 2 * PixW + QuadW;
	localparam int MDataW  = ((MFieldW + 7) / 8) * 8;

	typedef logic [1:0] phase_t;
	localparam phase_t PH_IDLE = 2'd0;
	localparam phase_t PH_REG1 = 2'd1;
	localparam phase_t PH_REG2 = 2'd2;
	localparam phase_t PH_DONE = 2'd3;

	localparam logic OP_START   = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

endpackage

>>> sv/midpoint_ellipse_rasterizer_top.sv
// Midpoint ellipse rasterizer: sequencer around one shared multiplier.
// Depends on mer_pkg.
`timescale 1ns / 1ps

// A start beat (tuser = 0) loads center and semi-axes and returns nothing.
// Each advance beat (tuser = 1) returns the next boundary point as four pixel
// beats, quadrants 0..3, the fourth with tlast; once the curve is finished it
// returns one beat with tuser = 1 and tlast. An advance waits out any output
// stall, and at the change from the x-stepping to the y-stepping region it
// also runs the region-2 setup before its test. All squares, decision tests
// and decision updates go through one 22x12 multiplier with a registered
// product, one operation per cycle. s_tready is high only between items.
module midpoint_ellipse_rasterizer_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// center_x, center_y, semi_a, semi_b (from bit 0), zero padded
	input  logic [mer_pkg::SDataW-1:0] s_tdata,
	// op
	input  logic                       s_tuser,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// pixel_x, pixel_y, quadrant (from bit 0), zero padded
	output logic [mer_pkg::MDataW-1:0] m_tdata,
	// done_res
	output logic                       m_tuser,
	output logic                       m_tlast
);

	localparam logic [3:0] ST_READY = 4'd0;
	localparam logic [3:0] ST_SQA   = 4'd1;
	localparam logic [3:0] ST_SQB   = 4'd2;
	localparam logic [3:0] ST_SQC   = 4'd3;
	localparam logic [3:0] ST_I0    = 4'd4;
	localparam logic [3:0] ST_I1    = 4'd5;
	localparam logic [3:0] ST_A1    = 4'd6;
	localparam logic [3:0] ST_A2    = 4'd7;
	localparam logic [3:0] ST_A3    = 4'd8;
	localparam logic [3:0] ST_EMIT  = 4'd9;
	localparam logic [3:0] ST_U1    = 4'd10;
	localparam logic [3:0] ST_U2    = 4'd11;
	localparam logic [3:0] ST_U3    = 4'd12;
	localparam logic [3:0] ST_U4    = 4'd13;
	localparam logic [3:0] ST_U5    = 4'd14;
	localparam logic [3:0] ST_DONEO = 4'd15;

	localparam int CX_LO = 0;
	localparam int CY_LO = CX_LO + mer_pkg::CoordW;
	localparam int SA_LO = CY_LO + mer_pkg::CoordW;
	localparam int SB_LO = SA_LO + mer_pkg::AxisW;

	logic [3:0]                  state_q;
	mer_pkg::phase_t             phase_q;
	logic [mer_pkg::CoordW-1:0]  cc_q, cr_q;
	logic [mer_pkg::AxisW-1:0]   axis_a_q, axis_b_q;
	logic [mer_pkg::SqW-1:0]     asq_q, bsq_q;
	logic [mer_pkg::OffW-1:0]    x_q, y_q;
	logic signed [mer_pkg::DecW-1:0] dec_q;
	logic [mer_pkg::ProdW-1:0]   prod_q, p1_q;
	logic                        pos_q;
	logic [mer_pkg::QuadW-1:0]   quad_q;

	logic                        out_valid_q;
	logic [mer_pkg::PixW-1:0]    out_px_q, out_py_q;
	logic [mer_pkg::QuadW-1:0]   out_quad_q;
	logic                        out_last_q, out_done_q;

	logic                        reg2;
	logic [mer_pkg::SqW-1:0]     sq_maj, sq_min;
	logic [mer_pkg::OffW-1:0]    off_maj, off_min;
	logic [mer_pkg::SqW-1:0]     mul_a;
	logic [mer_pkg::OffW-1:0]    mul_b;
	logic [mer_pkg::ProdW-1:0]   mul_p;
	logic                        out_free;
	logic                        out_load;
	logic                        in_acc;
	logic [mer_pkg::PixW-1:0]    pix_x, pix_y;

	// Region 1 steps x against b^2, region 2 steps y against a^2.
	assign reg2    = (phase_q == mer_pkg::PH_REG2);
	assign sq_maj  = reg2 ? asq_q : bsq_q;
	assign sq_min  = reg2 ? bsq_q : asq_q;
	assign off_maj = reg2 ? y_q : x_q;
	assign off_min = reg2 ? x_q : y_q;

	assign s_tready = (state_q == ST_READY);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign out_load = out_free && (state_q == ST_EMIT || state_q == ST_DONEO);

	always_comb begin
		unique case (state_q)
			ST_SQA: begin
				mul_a = mer_pkg::SqW'(axis_a_q);
				mul_b = mer_pkg::OffW'(axis_a_q);
			end
			ST_SQB: begin
				mul_a = mer_pkg::SqW'(axis_b_q);
				mul_b = mer_pkg::OffW'(axis_b_q);
			end
			ST_A1, ST_U1: begin
				mul_a = sq_maj;
				mul_b = off_maj;
			end
			ST_U2: begin
				mul_a = sq_maj;
				mul_b = mer_pkg::OffW'(4);
			end
			default: begin
				mul_a = sq_min;
				mul_b = off_min;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_comb begin
		if (quad_q[0] ^ quad_q[1]) begin
			pix_x = mer_pkg::PixW'(cc_q) - mer_pkg::PixW'(x_q);
		end else begin
			pix_x = mer_pkg::PixW'(cc_q) + mer_pkg::PixW'(x_q);
		end
		if (quad_q[1]) begin
			pix_y = mer_pkg::PixW'(cr_q) - mer_pkg::PixW'(y_q);
		end else begin
			pix_y = mer_pkg::PixW'(cr_q) + mer_pkg::PixW'(y_q);
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_READY;
			phase_q     <= mer_pkg::PH_IDLE;
			quad_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_READY: begin
					if (in_acc) begin
						if (s_tuser == mer_pkg::OP_START) begin
							phase_q <= mer_pkg::PH_REG1;
							state_q <= ST_SQA;
						end else if (phase_q == mer_pkg::PH_REG1 ||
							phase_q == mer_pkg::PH_REG2) begin
							state_q <= ST_A1;
						end else begin
							phase_q <= mer_pkg::PH_DONE;
							state_q <= ST_DONEO;
						end
					end
				end
				ST_SQA: state_q <= ST_SQB;
				ST_SQB: state_q <= ST_SQC;
				ST_SQC: state_q <= ST_I0;
				ST_I0:  state_q <= ST_I1;
				ST_I1: begin
					if (reg2) begin
						state_q <= ST_A1;
					end else begin
						if (axis_a_q == '0 || axis_b_q == '0) begin
							phase_q <= mer_pkg::PH_DONE;
						end
						state_q <= ST_READY;
					end
				end
				ST_A1: state_q <= ST_A2;
				ST_A2: state_q <= ST_A3;
				ST_A3: begin
					if (p1_q <= prod_q) begin
						quad_q  <= '0;
						state_q <= ST_EMIT;
					end else if (!reg2) begin
						phase_q <= mer_pkg::PH_REG2;
						state_q <= ST_I0;
					end else begin
						phase_q <= mer_pkg::PH_DONE;
						state_q <= ST_DONEO;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						quad_q <= quad_q + 1'b1;
						if (quad_q == mer_pkg::QuadW'(3)) begin
							state_q <= ST_U1;
						end
					end
				end
				ST_U1: state_q <= ST_U2;
				ST_U2: state_q <= ST_U3;
				ST_U3: state_q <= pos_q ? ST_U4 : ST_READY;
				ST_U4: state_q <= ST_U5;
				ST_U5: state_q <= ST_READY;
				ST_DONEO: begin
					if (out_free) begin
						state_q <= ST_READY;
					end
				end
				default: state_q <= ST_READY;
			endcase
		end
	end

	// Datapath registers; no reset needed.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_READY: begin
				if (in_acc && s_tuser == mer_pkg::OP_START) begin
					cc_q     <= s_tdata[CX_LO +: mer_pkg::CoordW];
					cr_q     <= s_tdata[CY_LO +: mer_pkg::CoordW];
					axis_a_q <= s_tdata[SA_LO +: mer_pkg::AxisW];
					axis_b_q <= s_tdata[SB_LO +: mer_pkg::AxisW];
					x_q      <= '0;
					y_q      <= mer_pkg::OffW'(s_tdata[SB_LO +: mer_pkg::AxisW]);
				end
			end
			ST_SQB: asq_q <= prod_q[mer_pkg::SqW-1:0];
			ST_SQC: bsq_q <= prod_q[mer_pkg::SqW-1:0];
			ST_I0: begin
				dec_q <= $signed(mer_pkg::DecW'({sq_maj, 2'b00}) +
					mer_pkg::DecW'(sq_min));
			end
			ST_I1: begin
				dec_q <= dec_q - $signed(mer_pkg::DecW'({prod_q, 2'b00}));
			end
			ST_A2: p1_q <= prod_q;
			ST_A3: begin
				pos_q <= (dec_q > 0);
				if (p1_q > prod_q && !reg2) begin
					// enter region 2 at (a, 0)
					x_q <= mer_pkg::OffW'(axis_a_q);
					y_q <= '0;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_px_q   <= pix_x;
					out_py_q   <= pix_y;
					out_quad_q <= quad_q;
					out_last_q <= (quad_q == mer_pkg::QuadW'(3));
					out_done_q <= 1'b0;
					if (quad_q == mer_pkg::QuadW'(3)) begin
						if (reg2) begin
							y_q <= y_q + 1'b1;
						end else begin
							x_q <= x_q + 1'b1;
						end
					end
				end
			end
			ST_U2: begin
				dec_q <= dec_q + $signed(mer_pkg::DecW'({prod_q, 3'b000}));
			end
			ST_U3: begin
				dec_q <= dec_q + $signed(mer_pkg::DecW'(prod_q));
				if (pos_q) begin
					if (reg2) begin
						x_q <= x_q - 1'b1;
					end else begin
						y_q <= y_q - 1'b1;
					end
				end
			end
			ST_U5: begin
				dec_q <= dec_q - $signed(mer_pkg::DecW'({prod_q, 3'b000}));
			end
			ST_DONEO: begin
				if (out_free) begin
					out_px_q   <= '0;
					out_py_q   <= '0;
					out_quad_q <= '0;
					out_last_q <= 1'b1;
					out_done_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(mer_pkg::MDataW - mer_pkg::MFieldW){1'b0}},
		out_quad_q, out_py_q, out_px_q};
	assign m_tuser  = out_done_q;
	assign m_tlast  = out_last_q;

	a_done_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
		else $error("done beat carries pixel data or lacks tlast");

	a_last_quad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tlast == (out_quad_q == mer_pkg::QuadW'(3))))
		else $error("tlast not on quadrant 3 of a point");

	a_ready_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !(m_tvalid && !m_tlast))
		else $error("input taken while a point is only partly sent");

	a_phase_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != mer_pkg::PH_IDLE) |=> (phase_q != mer_pkg::PH_IDLE))
		else $error("phase fell back to idle");

endmodule
